[src/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the speed frame receiver
// Holds the frame constants, the status codes and the structs that pass
// between the receiver's input stage, its parser and the top level.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0] FRAME_HEADER = 8'hA5;
  // Position of the checksum byte (bytes 0..9 are summed)
  localparam logic [3:0] SUM_POS      = 4'd10;
  localparam logic [3:0] PAYLOAD_POS  = 4'd2;
  localparam int unsigned NUM_SPEEDS  = 4;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SUM   = 2'd1,
    STATUS_NO_HEADER = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t                     status;
    logic [NUM_SPEEDS-1:0][15:0]       speed;
  } frame_result_t;

  typedef struct packed {
    logic [3:0] position;
    logic       first_is_header;
    logic       frame_done;
  } parser_status_t;

endpackage

[src/speed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// speed_frame_receiver: serial speed frame receiver
// Assembles 11-byte header framed packets, checks the 8-bit sum and holds
// four signed speed values from the last good frame.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and answers once per 11-byte frame
// (0xA5 header, command, four big-endian 16-bit speeds, mod-256 sum of
// bytes 0..9). A request is taken every cycle while the result side is not
// stalling; a byte is held in the input register and the frame's result
// appears in the output register on the cycle after its checksum byte
// leaves the input register. Throughput is set by the single state update
// per byte (position, header flag, running sum). Status 0 is a good frame
// and replaces the held speeds, 1 is a checksum mismatch and 2 a frame
// whose first byte was not a header; both keep the old speeds, which every
// result reports. A 0xA5 byte restarts framing only when the current frame
// did not start with 0xA5, and the command byte is not checked. While a
// result request is stalled the input register drains no further, and
// in_stall rises once it is full.
// ----------------------------------------------------------------------------
module speed_frame_receiver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_frame_status,
  output logic signed [15:0] out_speed_one,
  output logic signed [15:0] out_speed_two,
  output logic signed [15:0] out_speed_three,
  output logic signed [15:0] out_speed_four
);
  import sfr_pkg::*;

  logic           byte_valid;
  logic [7:0]     rx_byte;
  logic           take;
  frame_result_t  result;
  parser_status_t pstat;

  // input register
  sfr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .take       (take),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte)
  );

  // frame state and result register
  sfr_frame_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte),
    .take       (take),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result     (result),
    .status     (pstat)
  );

  assign out_frame_status = result.status;
  assign out_speed_one    = $signed(result.speed[0]);
  assign out_speed_two    = $signed(result.speed[1]);
  assign out_speed_three  = $signed(result.speed[2]);
  assign out_speed_four   = $signed(result.speed[3]);

  // position never passes the checksum byte
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pstat.position <= SUM_POS)
    else $error("frame position out of range");

  // the end of a frame clears framing state and shows a result
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    pstat.frame_done |=> (pstat.position == 4'd0) && !pstat.first_is_header && out_valid)
    else $error("frame end did not clear state or post a result");

  // stall toward the sender only with a byte held in the input register
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> byte_valid)
    else $error("input stalled while input register empty");

  // a result is only loaded while the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    pstat.frame_done |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

endmodule

[src/sfr_in_stage.sv]
// ----------------------------------------------------------------------------
// sfr_in_stage: input register of the speed frame receiver
// Captures one received byte per request and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module sfr_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] rx_byte
);
  import sfr_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  // full and not drained this cycle
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign rx_byte    = byte_r;

endmodule

[src/sfr_frame_parser.sv]
// ----------------------------------------------------------------------------
// sfr_frame_parser: frame state, checksum and held speeds
// Tracks position, header flag and running sum, stores the payload bytes
// and loads the result register at the end of every frame.
// ----------------------------------------------------------------------------
module sfr_frame_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_valid,
  input  logic [7:0]             rx_byte,
  output logic                   take,
  input  logic                   out_stall,
  output logic                   out_valid,
  output sfr_pkg::frame_result_t result,
  output sfr_pkg::parser_status_t status
);
  import sfr_pkg::*;

  logic [3:0]                  pos_r, pos_nxt;
  logic                        first_hdr_r, first_hdr_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  logic [7:0]                  payload_r [8];
  logic [NUM_SPEEDS-1:0][15:0] held_r, held_nxt;
  logic                        out_valid_r, out_valid_nxt;
  frame_result_t               result_r, result_nxt;

  logic                        restart;
  logic [3:0]                  pos_eff;
  logic [7:0]                  sum_eff;
  logic [2:0]                  pos_off;
  logic                        is_last;
  logic                        fire;
  logic                        done;
  logic                        wr_payload;
  logic [NUM_SPEEDS-1:0][15:0] frame_speed;

  // result register blocked while its request is stalled
  assign take = !(out_valid_r && out_stall);
  assign fire = byte_valid && take;

  // a header byte restarts the frame unless byte 0 already was a header
  assign restart    = (rx_byte == FRAME_HEADER) && !first_hdr_r;
  assign pos_eff    = restart ? 4'd0 : pos_r;
  assign sum_eff    = restart ? 8'd0 : sum_r;
  assign is_last    = (pos_eff >= SUM_POS);
  assign done       = fire && is_last;
  assign pos_off    = 3'(pos_eff - PAYLOAD_POS);
  assign wr_payload = fire && !is_last && (pos_eff >= PAYLOAD_POS);

  always_comb begin
    for (int i = 0; i < NUM_SPEEDS; i++) begin
      frame_speed[i] = {payload_r[2*i], payload_r[2*i+1]};
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    first_hdr_nxt = first_hdr_r;
    sum_nxt       = sum_r;
    held_nxt      = held_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      if (!is_last) begin
        if (pos_eff == 4'd0) begin
          first_hdr_nxt = (rx_byte == FRAME_HEADER);
        end
        sum_nxt = sum_eff + rx_byte;
        pos_nxt = pos_eff + 4'd1;
      end else begin
        if (!first_hdr_r) begin
          result_nxt.status = STATUS_NO_HEADER;
        end else if (sum_eff != rx_byte) begin
          result_nxt.status = STATUS_BAD_SUM;
        end else begin
          result_nxt.status = STATUS_OK;
          held_nxt          = frame_speed;
        end
        result_nxt.speed = held_nxt;
        out_valid_nxt    = 1'b1;
        pos_nxt          = 4'd0;
        first_hdr_nxt    = 1'b0;
        sum_nxt          = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 4'd0;
      first_hdr_r <= 1'b0;
      sum_r       <= 8'd0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      first_hdr_r <= first_hdr_nxt;
      sum_r       <= sum_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_payload) begin
      payload_r[pos_off] <= rx_byte;
    end
    result_r <= result_nxt;
  end

  assign out_valid              = out_valid_r;
  assign result                 = result_r;
  assign status.position        = pos_r;
  assign status.first_is_header = first_hdr_r;
  assign status.frame_done      = done;

endmodule

[tb/speed_frame_receiver_checker.sv]
// ----------------------------------------------------------------------------
// speed_frame_receiver_checker: result checker for the speed frame receiver
// Watches both channels, predicts one frame result per completed 11-byte
// frame from the accepted byte requests, and compares every accepted result
// request with the oldest predicted frame.
// ----------------------------------------------------------------------------
module speed_frame_receiver_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_frame_status,
  input  logic signed [15:0] out_speed_one,
  input  logic signed [15:0] out_speed_two,
  input  logic signed [15:0] out_speed_three,
  input  logic signed [15:0] out_speed_four,
  output int                 error_total,
  output int                 pending_frames
);
  import sfr_pkg::*;

  // Predicted framing state
  logic [3:0]                  byte_pos;
  logic                        header_seen;
  logic [7:0]                  byte_sum;
  logic [7:0]                  speed_bytes [8];
  logic [NUM_SPEEDS-1:0][15:0] held_speed;

  frame_result_t               expected_frames [$];
  frame_result_t               exp_frame;
  frame_result_t               new_frame;
  logic [NUM_SPEEDS-1:0][15:0] got_speed;
  int                          errors = 0;

  // Advance the framing state by one byte; returns 1 when the byte ends a frame.
  function automatic bit absorb_rx_byte(input logic [7:0] b, output frame_result_t res);
    res = '0;
    // a header only resyncs when the current frame did not start with one
    if (b == FRAME_HEADER && !header_seen) begin
      byte_pos = '0;
      byte_sum = '0;
    end
    if (byte_pos < SUM_POS) begin
      if (byte_pos == '0) begin
        header_seen = (b == FRAME_HEADER);
      end else if (byte_pos >= PAYLOAD_POS) begin
        speed_bytes[3'(byte_pos - PAYLOAD_POS)] = b;
      end
      byte_sum = byte_sum + b;
      byte_pos = byte_pos + 4'd1;
      return 1'b0;
    end
    // checksum byte
    if (!header_seen) begin
      res.status = STATUS_NO_HEADER;
    end else if (byte_sum != b) begin
      res.status = STATUS_BAD_SUM;
    end else begin
      res.status = STATUS_OK;
      for (int i = 0; i < NUM_SPEEDS; i++) begin
        held_speed[i] = {speed_bytes[2*i], speed_bytes[2*i+1]};
      end
    end
    res.speed   = held_speed;
    byte_pos    = '0;
    header_seen = 1'b0;
    byte_sum    = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_pos    = '0;
      header_seen = 1'b0;
      byte_sum    = '0;
      held_speed  = '0;
      for (int i = 0; i < 8; i++) begin
        speed_bytes[i] = '0;
      end
      expected_frames.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got_speed = {out_speed_four, out_speed_three, out_speed_two, out_speed_one};
        if (expected_frames.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected frame result: status %0d speeds %0d %0d %0d %0d",
                     out_frame_status, out_speed_one, out_speed_two,
                     out_speed_three, out_speed_four);
          end
        end else begin
          exp_frame = expected_frames.pop_front();
          if (out_frame_status !== exp_frame.status || got_speed !== exp_frame.speed) begin
            errors++;
            if (errors <= 10) begin
              $display("frame result mismatch: exp status %0d speeds %0d %0d %0d %0d",
                       exp_frame.status, $signed(exp_frame.speed[0]),
                       $signed(exp_frame.speed[1]), $signed(exp_frame.speed[2]),
                       $signed(exp_frame.speed[3]));
              $display("                       got status %0d speeds %0d %0d %0d %0d",
                       out_frame_status, out_speed_one, out_speed_two,
                       out_speed_three, out_speed_four);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (absorb_rx_byte(in_rx_byte, new_frame)) begin
          expected_frames.push_back(new_frame);
        end
      end
    end
    error_total    <= errors;
    pending_frames <= expected_frames.size();
  end

endmodule

[tb/speed_frame_receiver_tb.sv]
// ----------------------------------------------------------------------------
// speed_frame_receiver_tb: top of the speed frame receiver testbench
// Drives byte requests (directed frames, then random frames, broken frames
// and noise) with random gaps, stalls the result side at random with one
// long hold-off, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module speed_frame_receiver_tb;
  import sfr_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  // the last result follows its checksum byte; wait well past that
  localparam int DRAIN_CYCLES = 20;
  // long receiver hold-off, started once the sink has run this many cycles
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [1:0]         out_frame_status;
  logic signed [15:0] out_speed_one;
  logic signed [15:0] out_speed_two;
  logic signed [15:0] out_speed_three;
  logic signed [15:0] out_speed_four;

  int error_total;
  int pending_frames;
  int cycle_count = 0;
  int bytes_sent  = 0;
  bit no_gaps     = 1'b0;

  always #5 clk = ~clk;

  speed_frame_receiver DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_status (out_frame_status),
    .out_speed_one    (out_speed_one),
    .out_speed_two    (out_speed_two),
    .out_speed_three  (out_speed_three),
    .out_speed_four   (out_speed_four)
  );

  speed_frame_receiver_checker frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_status (out_frame_status),
    .out_speed_one    (out_speed_one),
    .out_speed_two    (out_speed_two),
    .out_speed_three  (out_speed_three),
    .out_speed_four   (out_speed_four),
    .error_total      (error_total),
    .pending_frames   (pending_frames)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Speeds lean on the signed extremes now and then.
  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // One byte request. Valid stays high straight into the next request when
  // there is no gap, so it is never dropped and raised in the same step.
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : pick_idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    // accepted at the first edge with stall low
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Full header frame; good_sum = 0 corrupts the checksum byte.
  task automatic send_frame(input logic [7:0] cmd,
                            input logic [NUM_SPEEDS-1:0][15:0] spd,
                            input bit good_sum);
    logic [7:0] frame_bytes [11];
    logic [7:0] total;
    frame_bytes[0] = FRAME_HEADER;
    frame_bytes[1] = cmd;
    for (int i = 0; i < NUM_SPEEDS; i++) begin
      // big-endian speed words
      frame_bytes[2+2*i] = spd[i][15:8];
      frame_bytes[3+2*i] = spd[i][7:0];
    end
    total = '0;
    for (int k = 0; k < SUM_POS; k++) begin
      total = total + frame_bytes[k];
    end
    frame_bytes[SUM_POS] = good_sum ? total : total + 8'($urandom_range(1, 255));
    for (int k = 0; k <= SUM_POS; k++) begin
      send_rx_byte(frame_bytes[k]);
    end
  endtask

  // Result side: random stalls, stall-free stretches, and one long hold-off
  // while the sender keeps going so the block backs up and stalls its input.
  initial begin : result_sink
    int n;
    int m;
    int sink_cycles;
    bit held;
    sink_cycles = 0;
    held        = 1'b0;
    forever begin
      n = pick_idle_cycles();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        sink_cycles += n;
      end
      out_stall <= 1'b0;
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      repeat (m) @(posedge clk);
      sink_cycles += m;
      if (!held && sink_cycles >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
    end
  end

  initial begin : byte_source
    logic [7:0]                  b;
    logic [NUM_SPEEDS-1:0][15:0] spd;
    int                          kind;
    int                          target;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // no header: eleven bytes, none of them 0xA5, with the 0x00 and 0xFF extremes
    for (int i = 0; i <= SUM_POS; i++) begin
      send_rx_byte(i == 1 ? 8'hFF : 8'(i * 8'h17));
    end
    // stray byte opens a headerless frame; the header that follows resyncs
    send_rx_byte(8'h00);
    // good frame with signed extremes and 0xA5 taken as command and data
    send_frame(FRAME_HEADER, {16'hFFFF, 16'hA5A5, 16'h8000, 16'h7FFF}, 1'b1);
    // bad checksum keeps the held speeds
    send_frame(8'h00, '0, 1'b0);

    // --- random ---
    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      kind    = $urandom_range(0, 99);
      if (kind < 60) begin
        for (int i = 0; i < NUM_SPEEDS; i++) begin
          spd[i] = pick_speed();
        end
        send_frame(8'($urandom), spd, $urandom_range(0, 4) != 0);
      end else if (kind < 72) begin
        // headerless frame
        for (int i = 0; i <= SUM_POS; i++) begin
          b = 8'($urandom);
          if (b == FRAME_HEADER) b = ~b;
          send_rx_byte(b);
        end
      end else if (kind < 86) begin
        // line noise
        repeat ($urandom_range(1, 6)) send_rx_byte(8'($urandom));
      end else begin
        // truncated frame
        send_rx_byte(FRAME_HEADER);
        repeat ($urandom_range(0, 9)) send_rx_byte(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    // drain: wait for every predicted frame, then let the pipeline settle
    @(posedge clk);
    while (pending_frames != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_total == 0 && pending_frames == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
